### rtl/cbsa_pkg.sv
// Shared types and constants for the chunked bitmap slot allocator.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package cbsa_pkg;

	// Geometry
	localparam int MAX_CHUNKS  = 16;
	localparam int SLOTS       = 64;
	localparam int CHUNK_W     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int OPEN_W      = $clog2(MAX_CHUNKS + 1);
	localparam int SLOT_W      = 6;
	localparam int ADDR_W      = CHUNK_W + SLOT_W;
	localparam int LIVE_W      = $clog2(MAX_CHUNKS * SLOTS + 1);
	localparam int CHUNK_IDX_W = 4;
	localparam int SEL_W       = 16;
	localparam int ID_W        = 64;

	// Commands
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// Result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Chunk choice for an allocate
	typedef struct packed {
		logic               hit;
		logic [CHUNK_W-1:0] chunk;
	} trk_sel_t;

	// Bookkeeping update from the datapath
	typedef struct packed {
		logic               open;
		logic               set_full;
		logic               clr_full;
		logic [CHUNK_W-1:0] chunk;
		logic               live_inc;
		logic               live_dec;
	} trk_upd_t;

	// Index of the lowest clear bit (map assumed to have one)
	function automatic logic [SLOT_W-1:0] lowest_zero(input logic [SLOTS-1:0] map);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int b = SLOTS - 1; b >= 0; b--) begin
			if (!map[b]) begin
				idx = SLOT_W'(b);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/cbsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/cbsa_chunk_track.sv
// Chunk bookkeeping: open-chunk count, per-chunk full flags, live slot count,
// and the choice of chunk for the next allocate. Depends on cbsa_pkg.
`default_nettype none

module cbsa_chunk_track (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cbsa_pkg::trk_upd_t        upd,
	output cbsa_pkg::trk_sel_t             sel,
	output logic [cbsa_pkg::OPEN_W-1:0]    chunks_open
);

	logic [cbsa_pkg::OPEN_W-1:0]     open_q;
	logic [cbsa_pkg::MAX_CHUNKS-1:0] full_q;
	logic [cbsa_pkg::LIVE_W-1:0]     live_q;
	logic [cbsa_pkg::MAX_CHUNKS-1:0] open_mask;

	// Chunks in use
	always_comb begin
		for (int i = 0; i < cbsa_pkg::MAX_CHUNKS; i++) begin
			open_mask[i] = (cbsa_pkg::OPEN_W'(i) < open_q);
		end
	end

	// Highest open chunk that still has a free slot
	always_comb begin
		sel = '0;
		for (int i = 0; i < cbsa_pkg::MAX_CHUNKS; i++) begin
			if (open_mask[i] && !full_q[i]) begin
				sel.hit   = 1'b1;
				sel.chunk = cbsa_pkg::CHUNK_W'(i);
			end
		end
	end

	assign chunks_open = open_q;

	// State updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			full_q <= '0;
			live_q <= '0;
		end else begin
			if (upd.open) begin
				open_q <= open_q + 1'b1;
			end
			if (upd.set_full) begin
				full_q[upd.chunk] <= 1'b1;
			end else if (upd.clr_full) begin
				full_q[upd.chunk] <= 1'b0;
			end
			if (upd.live_inc) begin
				live_q <= live_q + 1'b1;
			end else if (upd.live_dec) begin
				live_q <= live_q - 1'b1;
			end
		end
	end

	// Checks
	a_full_only_open: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q & ~open_mask) == '0)
		else $error("full flag set on a chunk that is not open");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= cbsa_pkg::OPEN_W'(cbsa_pkg::MAX_CHUNKS))
		else $error("open chunk count beyond capacity");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= cbsa_pkg::LIVE_W'(open_q) * cbsa_pkg::LIVE_W'(cbsa_pkg::SLOTS))
		else $error("live slot count exceeds slots of open chunks");

endmodule

`default_nettype wire

### rtl/chunked_bitmap_slot_allocator_unit.sv
// Chunked bitmap slot allocator: 16 chunks of 64 slots, a 64-bit valid bitmap
// per chunk and a 64-bit id per slot, both held in synchronous RAMs. Each item
// first reads the bitmap word and id entry, then updates, writes back and loads
// the result register, waiting while a held result is stalled. The next item is
// taken once the update is written, while the result may still wait in its output
// register. Allocate picks the highest open chunk that has a free slot from
// per-chunk full flags, then the lowest free slot in its bitmap. No clearing pass
// after reset. Depends on cbsa_pkg, cbsa_ram and cbsa_chunk_track.
`default_nettype none

module chunked_bitmap_slot_allocator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] node_id,
	input  wire logic [15:0] chunk_sel,
	input  wire logic [5:0]  slot_sel,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       chunk_index,
	output logic [5:0]       slot_index,
	output logic [63:0]      found_id
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	localparam int CW = cbsa_pkg::CHUNK_W;
	localparam int SW = cbsa_pkg::SLOT_W;
	localparam int AW = cbsa_pkg::ADDR_W;
	localparam int IW = cbsa_pkg::CHUNK_IDX_W;
	localparam int NS = cbsa_pkg::SLOTS;

	logic state_q;

	// Request registers
	logic [1:0]                 cmd_s1;
	logic [cbsa_pkg::ID_W-1:0]  node_id_s1;
	logic [cbsa_pkg::SEL_W-1:0] csel_s1;
	logic [SW-1:0]              ssel_s1;
	cbsa_pkg::trk_sel_t         sel_s1;

	// Result registers
	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [IW-1:0]              chunk_q;
	logic [SW-1:0]              slot_q;
	logic [cbsa_pkg::ID_W-1:0]  found_q;

	logic                        accept;
	logic                        exec;
	cbsa_pkg::trk_sel_t          sel;
	cbsa_pkg::trk_upd_t          upd;
	logic [cbsa_pkg::OPEN_W-1:0] chunks_open;

	logic          map_re;
	logic [CW-1:0] map_raddr;
	logic [NS-1:0] map_rd;
	logic          map_we;
	logic [CW-1:0] map_waddr;
	logic [NS-1:0] map_wd;

	logic          id_re;
	logic [AW-1:0] id_raddr;
	logic [63:0]   id_rd;
	logic          id_we;
	logic [AW-1:0] id_waddr;

	logic          in_range;
	logic          slot_set;
	logic [NS-1:0] slot_bit;
	logic [SW-1:0] free_slot;
	logic [NS-1:0] alloc_map;
	logic [CW-1:0] new_chunk;
	logic          can_open;

	logic [1:0]    res_status;
	logic [IW-1:0] res_chunk;
	logic [SW-1:0] res_slot;
	logic [63:0]   res_id;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign exec     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	cbsa_chunk_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.sel         (sel),
		.chunks_open (chunks_open)
	);

	// Reads issued on accept
	assign map_re    = accept;
	assign map_raddr = (cmd == cbsa_pkg::CMD_ALLOC) ? sel.chunk : chunk_sel[CW-1:0];
	assign id_re     = accept;
	assign id_raddr  = {chunk_sel[CW-1:0], slot_sel};

	cbsa_ram #(.WIDTH(NS), .DEPTH(cbsa_pkg::MAX_CHUNKS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wd),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rd)
	);

	cbsa_ram #(.WIDTH(cbsa_pkg::ID_W), .DEPTH(cbsa_pkg::MAX_CHUNKS * NS)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (node_id_s1),
		.re    (id_re),
		.raddr (id_raddr),
		.rdata (id_rd)
	);

	// Capture request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			node_id_s1 <= node_id;
			csel_s1    <= chunk_sel;
			ssel_s1    <= slot_sel;
			sel_s1     <= sel;
		end
	end

	// Decode of the read data
	assign in_range  = csel_s1 < cbsa_pkg::SEL_W'(chunks_open);
	assign slot_bit  = NS'(1) << ssel_s1;
	assign slot_set  = (map_rd & slot_bit) != '0;
	assign free_slot = cbsa_pkg::lowest_zero(map_rd);
	assign alloc_map = map_rd | (NS'(1) << free_slot);
	assign new_chunk = chunks_open[CW-1:0];
	assign can_open  = chunks_open < cbsa_pkg::OPEN_W'(cbsa_pkg::MAX_CHUNKS);

	// Update, write back and result
	always_comb begin
		map_we     = 1'b0;
		map_waddr  = sel_s1.chunk;
		map_wd     = alloc_map;
		id_we      = 1'b0;
		id_waddr   = {sel_s1.chunk, free_slot};
		upd        = '0;
		upd.chunk  = sel_s1.chunk;
		res_status = cbsa_pkg::ST_INVALID;
		res_chunk  = csel_s1[IW-1:0];
		res_slot   = ssel_s1;
		res_id     = '0;
		unique case (cmd_s1)
			cbsa_pkg::CMD_ALLOC: begin
				res_status = cbsa_pkg::ST_OK;
				if (sel_s1.hit) begin
					map_we       = exec;
					id_we        = exec;
					upd.live_inc = exec;
					upd.set_full = exec && (&alloc_map);
					res_chunk    = IW'(sel_s1.chunk);
					res_slot     = free_slot;
				end else if (can_open) begin
					map_we       = exec;
					map_waddr    = new_chunk;
					map_wd       = NS'(1);
					id_we        = exec;
					id_waddr     = {new_chunk, SW'(0)};
					upd.open     = exec;
					upd.live_inc = exec;
					res_chunk    = IW'(new_chunk);
					res_slot     = '0;
				end else begin
					res_status = cbsa_pkg::ST_FULL;
					res_chunk  = '0;
					res_slot   = '0;
				end
			end
			cbsa_pkg::CMD_FREE: begin
				map_waddr = csel_s1[CW-1:0];
				map_wd    = map_rd & ~slot_bit;
				upd.chunk = csel_s1[CW-1:0];
				if (in_range && slot_set) begin
					res_status   = cbsa_pkg::ST_OK;
					map_we       = exec;
					upd.clr_full = exec;
					upd.live_dec = exec;
				end
			end
			cbsa_pkg::CMD_LOOKUP: begin
				if (in_range && slot_set) begin
					res_status = cbsa_pkg::ST_OK;
					res_id     = id_rd;
				end
			end
			default: begin
				res_status = cbsa_pkg::ST_INVALID;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= ST_EXEC;
		end else if (exec) begin
			state_q <= ST_IDLE;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= res_status;
			chunk_q  <= res_chunk;
			slot_q   <= res_slot;
			found_q  <= res_id;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign chunk_index = chunk_q;
	assign slot_index  = slot_q;
	assign found_id    = found_q;

	// Checks
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted item did not move to execute");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without an executed item");

	a_hit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (cmd_s1 == cbsa_pkg::CMD_ALLOC) && sel_s1.hit) |-> !(&map_rd))
		else $error("chosen chunk has no free slot");

endmodule

`default_nettype wire

### bench/chunked_bitmap_slot_allocator_unit_test.sv
// Self-checking bench for chunked_bitmap_slot_allocator_unit: a bit-accurate allocator
// predictor in a scoreboard class and random request/result flow control.
// Depends on cbsa_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module chunked_bitmap_slot_allocator_unit_test;

	// Command code the block does not define
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]                       status;
		logic [cbsa_pkg::CHUNK_IDX_W-1:0] chunk;
		logic [cbsa_pkg::SLOT_W-1:0]      slot;
		logic [cbsa_pkg::ID_W-1:0]        id;
	} alloc_result_t;

	// Allocator predictor plus queue of awaited results
	class slot_alloc_scoreboard;
		logic [cbsa_pkg::SLOTS-1:0] bitmap [cbsa_pkg::MAX_CHUNKS];
		logic [cbsa_pkg::ID_W-1:0]  ids [cbsa_pkg::MAX_CHUNKS*cbsa_pkg::SLOTS];
		int                         open_chunks;
		int                         used_slots;
		alloc_result_t              awaited [$];
		int                         failures;

		function new();
			foreach (bitmap[k]) bitmap[k] = '0;
			open_chunks = 0;
			used_slots  = 0;
			failures    = 0;
		endfunction

		function void report(string what);
			$display("ERROR at %0t: %s", $realtime, what);
			failures++;
		endfunction

		// Apply one accepted request to the predicted state, queue its result
		function void predict_request(logic [1:0] op, logic [cbsa_pkg::ID_W-1:0] nid,
				logic [cbsa_pkg::SEL_W-1:0] csel, logic [cbsa_pkg::SLOT_W-1:0] ssel);
			alloc_result_t r;
			int k;
			int s;
			r.status = cbsa_pkg::ST_INVALID;
			r.chunk  = csel[cbsa_pkg::CHUNK_IDX_W-1:0];
			r.slot   = ssel;
			r.id     = '0;
			if (op == cbsa_pkg::CMD_ALLOC) begin
				r.status = cbsa_pkg::ST_FULL;
				r.chunk  = '0;
				r.slot   = '0;
				// highest open chunk with a hole, lowest hole in it
				for (k = open_chunks - 1; k >= 0 && r.status != cbsa_pkg::ST_OK; k--) begin
					for (s = 0; s < cbsa_pkg::SLOTS && r.status != cbsa_pkg::ST_OK;
							s++) begin
						if (!bitmap[k][s]) begin
							bitmap[k][s] = 1'b1;
							ids[k*cbsa_pkg::SLOTS + s] = nid;
							used_slots++;
							r.status = cbsa_pkg::ST_OK;
							r.chunk  = cbsa_pkg::CHUNK_IDX_W'(k);
							r.slot   = cbsa_pkg::SLOT_W'(s);
						end
					end
				end
				// all open chunks full: open a new one if any left
				if (r.status != cbsa_pkg::ST_OK && open_chunks < cbsa_pkg::MAX_CHUNKS) begin
					bitmap[open_chunks] = 64'd1;
					ids[open_chunks*cbsa_pkg::SLOTS] = nid;
					r.status = cbsa_pkg::ST_OK;
					r.chunk  = cbsa_pkg::CHUNK_IDX_W'(open_chunks);
					open_chunks++;
					used_slots++;
				end
			end else if (op == cbsa_pkg::CMD_FREE || op == cbsa_pkg::CMD_LOOKUP) begin
				if (csel < open_chunks) begin
					if (bitmap[csel][ssel]) begin
						r.status = cbsa_pkg::ST_OK;
						if (op == cbsa_pkg::CMD_FREE) begin
							bitmap[csel][ssel] = 1'b0;
							used_slots--;
						end else begin
							r.id = ids[csel*cbsa_pkg::SLOTS + ssel];
						end
					end
				end
			end
			awaited.push_back(r);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void compare_result(logic [1:0] st, logic [cbsa_pkg::CHUNK_IDX_W-1:0] ch,
				logic [cbsa_pkg::SLOT_W-1:0] sl, logic [cbsa_pkg::ID_W-1:0] id);
			alloc_result_t e;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status=%0d chunk=%0d slot=%0d",
					st, ch, sl));
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status)
				report($sformatf("status: expected %0d, got %0d", e.status, st));
			if (ch !== e.chunk)
				report($sformatf("chunk_index: expected %0d, got %0d", e.chunk, ch));
			if (sl !== e.slot)
				report($sformatf("slot_index: expected %0d, got %0d", e.slot, sl));
			if (id !== e.id)
				report($sformatf("found_id: expected %h, got %h", e.id, id));
		endfunction

		// Random handle of a currently valid slot
		function bit pick_live(output logic [cbsa_pkg::SEL_W-1:0] csel,
				output logic [cbsa_pkg::SLOT_W-1:0] ssel);
			int total;
			int start;
			int n;
			csel  = '0;
			ssel  = '0;
			total = open_chunks * cbsa_pkg::SLOTS;
			if (used_slots == 0)
				return 0;
			start = $urandom_range(total - 1);
			for (int i = 0; i < total; i++) begin
				n = (start + i) % total;
				if (bitmap[n / cbsa_pkg::SLOTS][n % cbsa_pkg::SLOTS]) begin
					csel = cbsa_pkg::SEL_W'(n / cbsa_pkg::SLOTS);
					ssel = cbsa_pkg::SLOT_W'(n % cbsa_pkg::SLOTS);
					return 1;
				end
			end
			return 0;
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [1:0]                  cmd;
	logic [cbsa_pkg::ID_W-1:0]   node_id;
	logic [cbsa_pkg::SEL_W-1:0]  chunk_sel;
	logic [cbsa_pkg::SLOT_W-1:0] slot_sel;
	logic                        out_valid;
	logic                        out_stall;
	logic [1:0]                  status;
	logic [3:0]                  chunk_index;
	logic [5:0]                  slot_index;
	logic [63:0]                 found_id;

	slot_alloc_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int cycles = 0;

	chunked_bitmap_slot_allocator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.node_id     (node_id),
		.chunk_sel   (chunk_sel),
		.slot_sel    (slot_sel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.chunk_index (chunk_index),
		.slot_index  (slot_index),
		.found_id    (found_id)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: check accepted items, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.compare_result(status, chunk_index, slot_index, found_id);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [cbsa_pkg::ID_W-1:0] rand_id();
		return {$urandom, $urandom};
	endfunction

	// Present one item after optional idle cycles; return once it is taken
	task automatic send_item(input logic [1:0] op, input logic [cbsa_pkg::ID_W-1:0] nid,
			input logic [cbsa_pkg::SEL_W-1:0] csel, input logic [cbsa_pkg::SLOT_W-1:0] ssel);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		node_id   <= nid;
		chunk_sel <= csel;
		slot_sel  <= ssel;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.predict_request(op, nid, csel, ssel);
	endtask

	// Allocates and handles of live slots, plus stale, out-of-range and unused requests
	task automatic send_random();
		int unsigned pick;
		logic [cbsa_pkg::SEL_W-1:0] cs;
		logic [cbsa_pkg::SLOT_W-1:0] ss;
		pick = $urandom_range(99);
		if (pick < 40)
			send_item(cbsa_pkg::CMD_ALLOC, rand_id(), cbsa_pkg::SEL_W'($urandom),
				cbsa_pkg::SLOT_W'($urandom));
		else if (pick < 75 && sb.pick_live(cs, ss))
			send_item((pick < 62) ? cbsa_pkg::CMD_FREE : cbsa_pkg::CMD_LOOKUP,
				rand_id(), cs, ss);
		else if (pick < 92)
			send_item(pick[0] ? cbsa_pkg::CMD_FREE : cbsa_pkg::CMD_LOOKUP, rand_id(),
				cbsa_pkg::SEL_W'($urandom_range(sb.open_chunks)),
				cbsa_pkg::SLOT_W'($urandom));
		else if (pick < 97)
			send_item(pick[0] ? cbsa_pkg::CMD_FREE : cbsa_pkg::CMD_LOOKUP, rand_id(),
				cbsa_pkg::SEL_W'($urandom), cbsa_pkg::SLOT_W'($urandom));
		else
			send_item(CMD_UNUSED, rand_id(), cbsa_pkg::SEL_W'($urandom),
				cbsa_pkg::SLOT_W'($urandom));
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cmd       = cbsa_pkg::CMD_ALLOC;
		node_id   = '0;
		chunk_sel = '0;
		slot_sel  = '0;
		out_stall = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty allocator, field extremes, reuse of a freed slot
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_FREE, '1, 16'hFFFF, 6'd63);
		send_item(CMD_UNUSED, '1, 16'hFFFF, 6'd63);
		send_item(cbsa_pkg::CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 6'd63);
		send_item(cbsa_pkg::CMD_ALLOC, 64'h0, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_ALLOC, 64'h0000_0000_FFFF_FFFF, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_LOOKUP, '1, 16'h0000, 6'd1);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd2);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd63);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0010, 6'd0);
		send_item(cbsa_pkg::CMD_FREE, '0, 16'h0000, 6'd1);
		send_item(cbsa_pkg::CMD_FREE, '0, 16'h0000, 6'd1);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd1);
		send_item(cbsa_pkg::CMD_ALLOC, 64'hFFFF_FFFF_0000_0000, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0000, 6'd1);
		send_item(CMD_UNUSED, '0, 16'h0000, 6'd0);
		send_item(cbsa_pkg::CMD_FREE, '0, 16'h8000, 6'd0);
		send_item(cbsa_pkg::CMD_LOOKUP, '0, 16'h0001, 6'd0);
		send_item(cbsa_pkg::CMD_FREE, '0, 16'h0000, 6'd2);

		// Random phases with different flow control
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 52;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 52;
				end
				default: begin
					idle_pct  = 24;
					stall_pct = 24;
				end
			endcase
			// last phase: fill every chunk, hit the full case, then churn
			if (phase == 3) begin
				while (sb.used_slots < cbsa_pkg::MAX_CHUNKS * cbsa_pkg::SLOTS)
					send_item(cbsa_pkg::CMD_ALLOC, rand_id(), cbsa_pkg::SEL_W'($urandom),
						cbsa_pkg::SLOT_W'($urandom));
				repeat (3)
					send_item(cbsa_pkg::CMD_ALLOC, rand_id(), cbsa_pkg::SEL_W'($urandom),
						cbsa_pkg::SLOT_W'($urandom));
			end
			repeat (150)
				send_random();
		end
		in_valid <= 1'b0;

		// Drain
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
